[design/msc_pkg.sv]
// shared types and constants for the media stream coprocessor register block
package msc_pkg;

	// command codes carried by each input word
	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} msc_cmd_t;

	// register window
	localparam logic [15:0] REG_BASE = 16'h2000;

	// register offsets inside the window
	localparam logic [2:0] REG_STATUS = 3'd0;
	localparam logic [2:0] REG_DATA   = 3'd1;
	localparam logic [2:0] REG_ID0    = 3'd2;
	localparam logic [2:0] REG_ID1    = 3'd3;
	localparam logic [2:0] REG_ID2    = 3'd4;
	localparam logic [2:0] REG_ID3    = 3'd5;
	localparam logic [2:0] REG_ID4    = 3'd6;
	localparam logic [2:0] REG_ID5    = 3'd7;

	// write map aliases
	localparam logic [2:0] REG_DOFS0  = 3'd0;
	localparam logic [2:0] REG_DOFS1  = 3'd1;
	localparam logic [2:0] REG_DOFS2  = 3'd2;
	localparam logic [2:0] REG_DOFS3  = 3'd3;
	localparam logic [2:0] REG_TRACK0 = 3'd4;
	localparam logic [2:0] REG_TRACK1 = 3'd5;
	localparam logic [2:0] REG_VOLUME = 3'd6;
	localparam logic [2:0] REG_CTRL   = 3'd7;

	// id string characters
	localparam logic [7:0] CHR_S     = 8'h53;
	localparam logic [7:0] CHR_DASH  = 8'h2d;
	localparam logic [7:0] CHR_M     = 8'h4d;
	localparam logic [7:0] CHR_U     = 8'h55;
	localparam logic [7:0] CHR_ZERO  = 8'h30;

	// audio header length skipped on load and rewind
	localparam logic [31:0] HEADER_SKIP = 32'd58;
	localparam logic [31:0] SAMPLE_BYTES = 32'd4;

	// reset volume
	localparam logic [7:0] VOLUME_RST = 8'hff;

	// request flags produced per word
	typedef struct packed {
		logic data_read;
		logic data_seek;
		logic track_load;
		logic audio_seek;
		logic audio_read;
	} msc_req_t;

endpackage

[design/msc_scale.sv]
// volume scaler: sample * volume / 255, truncated toward zero
module msc_scale import msc_pkg::*; (
	input  logic signed [15:0] sample,
	input  logic        [7:0]  volume,
	output logic signed [15:0] scaled
);

	logic        neg;
	logic [16:0] mag;
	logic [23:0] prod;
	logic [31:0] recip_sum;
	logic [15:0] quot_est;
	logic [23:0] rem;
	logic [15:0] quot;

	// magnitude times volume, then divide by 255 via reciprocal 257/65536
	always_comb begin
		neg       = sample[15];
		mag       = neg ? (17'd0 - {1'b1, sample}) : {1'b0, sample};
		prod      = {7'd0, mag} * {16'd0, volume};
		recip_sum = {8'd0, prod} + {prod, 8'd0};
		quot_est  = recip_sum[31:16];
		// estimate is low by at most one
		rem       = prod - ({quot_est, 8'd0} - {8'd0, quot_est});
		quot      = (rem >= 24'd255) ? (quot_est + 16'd1) : quot_est;
		scaled    = neg ? $signed(16'd0 - quot) : $signed(quot);
	end

endmodule

[design/msc_regs.sv]
// register state, address decode and audio tick control
module msc_regs import msc_pkg::*; #(
	parameter int unsigned REVISION = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        commit,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic        data_file_open,
	input  logic [7:0]  data_file_byte,
	input  logic        audio_file_open,
	input  logic        audio_file_end,
	output logic [7:0]  read_data,
	output msc_req_t    req,
	output logic [31:0] data_offset_nxt,
	output logic [15:0] track_nxt,
	output logic [31:0] audio_offset_nxt,
	output logic [7:0]  volume
);

	localparam logic [3:0] REV_NIB = 4'(REVISION);

	logic [31:0] data_offset_q;
	logic [31:0] audio_offset_q;
	logic [15:0] track_q;
	logic [7:0]  volume_q;
	logic        data_busy_q;
	logic        audio_busy_q;
	logic        repeat_q;
	logic        play_q;

	logic        data_busy_nxt;
	logic        audio_busy_nxt;
	logic        repeat_nxt;
	logic        play_nxt;
	logic [7:0]  volume_nxt;
	logic        in_window;
	logic [2:0]  reg_idx;

	assign in_window = (address[15:3] == REG_BASE[15:3]);
	assign reg_idx   = address[2:0];
	assign volume    = volume_q;

	// next state and per-word outputs
	always_comb begin
		read_data        = 8'd0;
		req              = '0;
		data_offset_nxt  = data_offset_q;
		audio_offset_nxt = audio_offset_q;
		track_nxt        = track_q;
		volume_nxt       = volume_q;
		data_busy_nxt    = data_busy_q;
		audio_busy_nxt   = audio_busy_q;
		repeat_nxt       = repeat_q;
		play_nxt         = play_q;
		unique case (command)
			CMD_READ: begin
				if (in_window) begin
					unique case (reg_idx)
						REG_STATUS: read_data = {data_busy_q, audio_busy_q, repeat_q,
							play_q, REV_NIB};
						REG_DATA: begin
							if (!data_busy_q) begin
								data_offset_nxt = data_offset_q + 32'd1;
								if (data_file_open) begin
									read_data     = data_file_byte;
									req.data_read = 1'b1;
								end
							end
						end
						REG_ID0: read_data = CHR_S;
						REG_ID1: read_data = CHR_DASH;
						REG_ID2: read_data = CHR_M;
						REG_ID3: read_data = CHR_S;
						REG_ID4: read_data = CHR_U;
						REG_ID5: read_data = CHR_ZERO + {4'd0, REV_NIB};
						default: read_data = 8'd0;
					endcase
				end
			end
			CMD_WRITE: begin
				if (in_window) begin
					unique case (reg_idx)
						REG_DOFS0: data_offset_nxt[7:0]   = write_data;
						REG_DOFS1: data_offset_nxt[15:8]  = write_data;
						REG_DOFS2: data_offset_nxt[23:16] = write_data;
						REG_DOFS3: begin
							data_offset_nxt[31:24] = write_data;
							req.data_seek          = data_file_open;
							data_busy_nxt          = 1'b0;
						end
						REG_TRACK0: track_nxt[7:0] = write_data;
						REG_TRACK1: begin
							track_nxt[15:8] = write_data;
							req.track_load  = 1'b1;
							if (audio_file_open) begin
								audio_offset_nxt = HEADER_SKIP;
								req.audio_seek   = 1'b1;
							end
							audio_busy_nxt = 1'b0;
							repeat_nxt     = 1'b0;
							play_nxt       = 1'b0;
						end
						REG_VOLUME: volume_nxt = write_data;
						REG_CTRL: begin
							repeat_nxt = write_data[1];
							play_nxt   = write_data[0];
						end
						default: volume_nxt = volume_q;
					endcase
				end
			end
			CMD_TICK: begin
				if (play_q) begin
					if (!audio_file_open) begin
						play_nxt = 1'b0;
					end else if (audio_file_end) begin
						// rewind past the header, stop unless looping
						play_nxt         = repeat_q;
						audio_offset_nxt = HEADER_SKIP;
						req.audio_seek   = 1'b1;
					end else begin
						audio_offset_nxt = audio_offset_q + SAMPLE_BYTES;
						req.audio_read   = 1'b1;
					end
				end
			end
			default: read_data = 8'd0;
		endcase
	end

	// state update when the word moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_offset_q  <= '0;
			audio_offset_q <= '0;
			track_q        <= '0;
			volume_q       <= VOLUME_RST;
			data_busy_q    <= 1'b1;
			audio_busy_q   <= 1'b1;
			repeat_q       <= 1'b0;
			play_q         <= 1'b0;
		end else if (commit) begin
			data_offset_q  <= data_offset_nxt;
			audio_offset_q <= audio_offset_nxt;
			track_q        <= track_nxt;
			volume_q       <= volume_nxt;
			data_busy_q    <= data_busy_nxt;
			audio_busy_q   <= audio_busy_nxt;
			repeat_q       <= repeat_nxt;
			play_q         <= play_nxt;
		end
	end

	// a sample read and a rewind never happen on the same word
	assert property (@(posedge clk) disable iff (!arst_n)
		!(req.audio_read && req.audio_seek))
		else $error("audio read and seek together");

	// the data offset only moves on a read or a write of the data registers
	assert property (@(posedge clk) disable iff (!arst_n)
		(commit && command == CMD_TICK) |=> $stable(data_offset_q))
		else $error("data offset changed on a tick");

	// play never turns on from a tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(commit && command == CMD_TICK && !play_q) |=> !play_q)
		else $error("tick started playback");

endmodule

[design/media_stream_coprocessor_regs.sv]
// top level: input register, register and tick logic, result register
// each accepted input word is held in the input register, then in the result register
// throughput: one word per cycle while the output is not stalled, each word decoded and
// applied in a single pass between the input register and the result register
// reset: asynchronous, offsets and track cleared, volume 255, both busy flags set,
// repeat and play cleared, both pipeline stages empty
module media_stream_coprocessor_regs import msc_pkg::*; #(
	parameter int unsigned REVISION = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [15:0]        address,
	input  logic [7:0]         write_data,
	input  logic               data_file_open,
	input  logic [7:0]         data_file_byte,
	input  logic               audio_file_open,
	input  logic               audio_file_end,
	input  logic signed [15:0] sample_left,
	input  logic signed [15:0] sample_right,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         read_data,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	output logic               data_read_request,
	output logic               data_seek_request,
	output logic [31:0]        data_offset_out,
	output logic               track_load_request,
	output logic [15:0]        track_number,
	output logic               audio_seek_request,
	output logic [31:0]        audio_offset_out,
	output logic               audio_read_request
);

	logic               valid_s1;
	logic [1:0]         command_s1;
	logic [15:0]        address_s1;
	logic [7:0]         write_data_s1;
	logic               data_file_open_s1;
	logic [7:0]         data_file_byte_s1;
	logic               audio_file_open_s1;
	logic               audio_file_end_s1;
	logic signed [15:0] sample_left_s1;
	logic signed [15:0] sample_right_s1;

	logic               valid_s2;
	logic               load_s2;
	logic               load_s1;

	logic [7:0]         read_data_c;
	msc_req_t           req_c;
	logic [31:0]        data_offset_c;
	logic [15:0]        track_c;
	logic [31:0]        audio_offset_c;
	logic [7:0]         volume_c;
	logic signed [15:0] left_scaled;
	logic signed [15:0] right_scaled;

	// pipeline flow control
	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign load_s1  = in_valid && !in_stall;

	// input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || load_s2) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			command_s1         <= command;
			address_s1         <= address;
			write_data_s1      <= write_data;
			data_file_open_s1  <= data_file_open;
			data_file_byte_s1  <= data_file_byte;
			audio_file_open_s1 <= audio_file_open;
			audio_file_end_s1  <= audio_file_end;
			sample_left_s1     <= sample_left;
			sample_right_s1    <= sample_right;
		end
	end

	// register file and tick control
	msc_regs #(
		.REVISION(REVISION)
	) u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.commit          (load_s2),
		.command         (command_s1),
		.address         (address_s1),
		.write_data      (write_data_s1),
		.data_file_open  (data_file_open_s1),
		.data_file_byte  (data_file_byte_s1),
		.audio_file_open (audio_file_open_s1),
		.audio_file_end  (audio_file_end_s1),
		.read_data       (read_data_c),
		.req             (req_c),
		.data_offset_nxt (data_offset_c),
		.track_nxt       (track_c),
		.audio_offset_nxt(audio_offset_c),
		.volume          (volume_c)
	);

	// volume scaling, one per channel
	msc_scale u_scale_left (
		.sample(sample_left_s1),
		.volume(volume_c),
		.scaled(left_scaled)
	);

	msc_scale u_scale_right (
		.sample(sample_right_s1),
		.volume(volume_c),
		.scaled(right_scaled)
	);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2 || !out_stall) begin
			valid_s2 <= load_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			read_data          <= read_data_c;
			left_out           <= req_c.audio_read ? left_scaled : 16'sd0;
			right_out          <= req_c.audio_read ? right_scaled : 16'sd0;
			data_read_request  <= req_c.data_read;
			data_seek_request  <= req_c.data_seek;
			data_offset_out    <= data_offset_c;
			track_load_request <= req_c.track_load;
			track_number       <= track_c;
			audio_seek_request <= req_c.audio_seek;
			audio_offset_out   <= audio_offset_c;
			audio_read_request <= req_c.audio_read;
		end
	end

	assign out_valid = valid_s2;

	// input is held off only when both stages are full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

	// samples are silent unless a sample pair was consumed
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !audio_read_request) |-> (left_out == 16'sd0 && right_out == 16'sd0))
		else $error("sample output without audio read");

	// a held result word keeps its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(audio_offset_out)
			&& $stable(data_offset_out)))
		else $error("result word changed while stalled");

	// a data read and a data seek never come from the same word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(data_read_request && data_seek_request))
		else $error("data read and seek together");

endmodule
